[rtl/core/rme_pkg.sv]
// Package for the rotation matrix to Euler angles block.
// Holds the fixed widths, the CORDIC arctangent table, stage counts and pole codes.
// Used by rme_cordic and rotation_matrix_to_euler; depends on nothing else.
package rme_pkg;

  // Number of CORDIC iterations and the length of the arctangent table.
  localparam int CordicStages = 16;
  localparam int TabLen       = 24;
  localparam int CsN          = (CordicStages < TabLen) ? CordicStages : TabLen;

  // Datapath widths: vectors are Q1.22, angles are in units of 2^-20 rad.
  localparam int VecW = 28;
  localparam int AngW = 24;
  localparam int OutW = AngW - 7;

  // Integer square root: 23 result bits, two bits resolved per stage.
  localparam int SqSteps  = 23;
  localparam int SqStages = (SqSteps + 1) / 2;
  localparam int SqW      = 46;

  localparam logic signed [AngW-1:0] AngPi = AngW'(3294199);

  // Pitch at the poles, pi/2 in Q3.13.
  localparam logic signed [14:0] PitchHalfPi = 15'sd12868;

  // atan(2^-i) in units of 2^-20 rad, rounded to nearest.
  localparam logic [AngW-1:0] AtanTab [TabLen] = '{
    24'd823550, 24'd486170, 24'd256879, 24'd130396, 24'd65451, 24'd32757,
    24'd16383,  24'd8192,   24'd4096,   24'd2048,   24'd1024,  24'd512,
    24'd256,    24'd128,    24'd64,     24'd32,     24'd16,    24'd8,
    24'd4,      24'd2,      24'd1,      24'd0,      24'd0,     24'd0
  };

  // Branch taken for one matrix.
  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

endpackage

[rtl/core/rme_cordic.sv]
// Pipelined vectoring CORDIC that returns atan2(y, x) in signed Q3.13.
// One register for the quadrant fold, then one register per iteration.
// Depends on rme_pkg.
module rme_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic signed [rme_pkg::VecW-1:0]  y_i,
  input  logic signed [rme_pkg::VecW-1:0]  x_i,
  output logic signed [rme_pkg::OutW-1:0]  ang_o
);
  import rme_pkg::*;

  logic signed [VecW-1:0] x_q [CsN+1];
  logic signed [VecW-1:0] y_q [CsN+1];
  logic signed [AngW-1:0] z_q [CsN+1];
  logic                   zero_q [CsN+1];

  logic signed [VecW-1:0] x0_d, y0_d;
  logic signed [AngW-1:0] z0_d;
  logic signed [AngW-1:0] z_rnd;

  // Fold a vector with negative x into the right half plane.
  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    z0_d = '0;
    if (x_i < 0) begin
      x0_d = -x_i;
      y0_d = -y_i;
      z0_d = (y_i >= 0) ? AngPi : -AngPi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q[0] <= 1'b0;
    end else if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
    end
  end

  // One micro-rotation per stage, steering y toward zero.
  for (genvar i = 0; i < CsN; i++) begin : g_iter
    logic signed [VecW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        zero_q[i+1] <= 1'b0;
      end else if (en_i) begin
        zero_q[i+1] <= zero_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + $signed(AtanTab[i]);
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - $signed(AtanTab[i]);
        end
      end
    end
  end

  // Round to Q3.13; a zero vector gives angle zero.
  assign z_rnd = z_q[CsN] + AngW'(64);
  assign ang_o = zero_q[CsN] ? '0 : OutW'(z_rnd >>> 7);

endmodule

[rtl/core/rotation_matrix_to_euler.sv]
// Rotation matrix to Euler angles: top level with handshake, pole test, square root.
// Instantiates three rme_cordic pipelines; depends on rme_pkg.
//
// The block accepts one matrix per clock cycle unless the output is held, and
// returns roll, pitch and yaw through 4 + 12 square-root stages + 16 CORDIC
// stages with the default 16 CORDIC iterations (the four are the operand
// register, the sine square, the CORDIC quadrant fold and the output register).
// The depth is set by the square-root pipeline for the pitch cosine followed
// by the CORDIC iteration stages. The whole pipeline advances together; when the
// output is held by a low m_axis_tready, input is held as well and nothing is
// lost or repeated. The pole threshold may be written at any time the block is idle.
module rotation_matrix_to_euler (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: pole_threshold.
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i,
  // Input: row0_col0, row0_col2, row1_col0, row1_col1, row1_col2, row2_col0,
  // row2_col2, 16 bits each from the lowest bit up.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  // Output: roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31], zero pad.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,
  // Output: pole_case [1:0].
  output logic [1:0]   m_axis_tuser
);
  import rme_pkg::*;

  localparam int Depth = 3 + SqStages + CsN;
  localparam int OpDly = SqStages + 2;

  typedef struct packed {
    logic signed [VecW-1:0] roll_y;
    logic signed [VecW-1:0] roll_x;
    logic signed [VecW-1:0] yaw_y;
    logic signed [VecW-1:0] yaw_x;
    logic signed [15:0]     sin_v;
  } ops_t;

  typedef struct packed {
    logic [SqW-1:0] v;
    logic [SqW-1:0] r;
  } sq_t;

  logic [14:0] pole_threshold_q;
  logic        en;
  logic        valid_q [Depth];
  pole_e       pole_q  [Depth];
  ops_t        ops_q   [OpDly];
  logic [28:0] sq_q;
  sq_t         sqs_q   [SqStages];

  logic signed [15:0] m00, m02, m10, m11, m12, m20, m22;
  logic signed [16:0] thr_pos, thr_neg;
  pole_e              pole_d;
  ops_t               ops_d;

  logic signed [OutW-1:0] roll_ang, pitch_ang, yaw_ang;
  logic signed [15:0]     roll_out_d, yaw_out_d;
  logic signed [14:0]     pitch_out_d;

  logic         out_valid_q;
  logic [47:0]  out_data_q;
  pole_e        out_pole_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_threshold_q <= 15'd16351;
    end else if (cfg_we_i) begin
      pole_threshold_q <= cfg_wdata_i;
    end
  end

  // The pipeline moves whenever the output register is free or drained.
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign m00 = s_axis_tdata[15:0];
  assign m02 = s_axis_tdata[31:16];
  assign m10 = s_axis_tdata[47:32];
  assign m11 = s_axis_tdata[63:48];
  assign m12 = s_axis_tdata[79:64];
  assign m20 = s_axis_tdata[95:80];
  assign m22 = s_axis_tdata[111:96];

  assign thr_pos = $signed({2'b00, pole_threshold_q});
  assign thr_neg = -thr_pos;

  // Pole test, sine saturation and CORDIC operand selection.
  always_comb begin
    if (17'(m10) > thr_pos) begin
      pole_d = POLE_NORTH;
    end else if (17'(m10) < thr_neg) begin
      pole_d = POLE_SOUTH;
    end else begin
      pole_d = POLE_NONE;
    end

    if (m10 > 16'sd16384) begin
      ops_d.sin_v = 16'sd16384;
    end else if (m10 < -16'sd16384) begin
      ops_d.sin_v = -16'sd16384;
    end else begin
      ops_d.sin_v = m10;
    end

    ops_d.roll_y = (-VecW'(m12)) <<< 8;
    ops_d.roll_x = VecW'(m11) <<< 8;
    if (pole_d == POLE_NONE) begin
      ops_d.yaw_y = (-VecW'(m20)) <<< 8;
      ops_d.yaw_x = VecW'(m00) <<< 8;
    end else begin
      ops_d.yaw_y = VecW'(m02) <<< 8;
      ops_d.yaw_x = VecW'(m22) <<< 8;
    end
  end

  // Valid bits and pole codes travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        valid_q[i] <= 1'b0;
        pole_q[i]  <= POLE_NONE;
      end
    end else if (en) begin
      valid_q[0] <= s_axis_tvalid;
      pole_q[0]  <= pole_d;
      for (int i = 1; i < Depth; i++) begin
        valid_q[i] <= valid_q[i-1];
        pole_q[i]  <= pole_q[i-1];
      end
    end
  end

  // Operand delay line up to the CORDIC inputs, and the sine square.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ops_q[0] <= ops_d;
      for (int i = 1; i < OpDly; i++) begin
        ops_q[i] <= ops_q[i-1];
      end
      sq_q <= 29'(ops_q[0].sin_v * ops_q[0].sin_v);
    end
  end

  // Integer square root of 2^44 - (s*256)^2, two result bits per stage.
  for (genvar k = 0; k < SqStages; k++) begin : g_sqrt
    sq_t sq_in, sq_d;
    logic [SqW-1:0] bit_v, trial;

    if (k == 0) begin : g_first
      assign sq_in.v = (SqW'(1) << 44) - {1'b0, sq_q, 16'b0};
      assign sq_in.r = '0;
    end else begin : g_rest
      assign sq_in = sqs_q[k-1];
    end

    always_comb begin
      sq_d  = sq_in;
      bit_v = '0;
      trial = '0;
      for (int j = 2 * k; j < 2 * k + 2; j++) begin
        if (j < SqSteps) begin
          bit_v = SqW'(1) << (44 - 2 * j);
          trial = sq_d.r + bit_v;
          if (sq_d.v >= trial) begin
            sq_d.v = sq_d.v - trial;
            sq_d.r = (sq_d.r >> 1) + bit_v;
          end else begin
            sq_d.r = sq_d.r >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqs_q[k] <= sq_d;
      end
    end
  end

  // Three arctangent pipelines: roll, pitch (asin) and yaw.
  rme_cordic u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .y_i    (ops_q[OpDly-1].roll_y),
    .x_i    (ops_q[OpDly-1].roll_x),
    .ang_o  (roll_ang)
  );

  rme_cordic u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .y_i    (VecW'(ops_q[OpDly-1].sin_v) <<< 8),
    .x_i    ($signed(VecW'(sqs_q[SqStages-1].r))),
    .ang_o  (pitch_ang)
  );

  rme_cordic u_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .y_i    (ops_q[OpDly-1].yaw_y),
    .x_i    (ops_q[OpDly-1].yaw_x),
    .ang_o  (yaw_ang)
  );

  // Select pole constants and truncate to the output widths.
  always_comb begin
    yaw_out_d = 16'(yaw_ang);
    case (pole_q[Depth-1])
      POLE_NORTH: begin
        roll_out_d  = '0;
        pitch_out_d = PitchHalfPi;
      end
      POLE_SOUTH: begin
        roll_out_d  = '0;
        pitch_out_d = -PitchHalfPi;
      end
      default: begin
        roll_out_d  = 16'(roll_ang);
        pitch_out_d = 15'(pitch_ang);
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {1'b0, yaw_out_d, pitch_out_d, roll_out_d};
      out_pole_q <= pole_q[Depth-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_pole_q;

endmodule

[tb/rotation_matrix_to_euler_test.sv]
// Testbench for rotation_matrix_to_euler: streams matrices, predicts the Euler angles
// with a fixed-point CORDIC model of its own and checks every output transfer.
// Depends on rme_pkg and the rotation_matrix_to_euler RTL only.
`timescale 1ns / 1ps

module rotation_matrix_to_euler_test;
  import rme_pkg::*;

  localparam int  ThrReset   = 16351;
  localparam int  SettleCyc  = 40;
  localparam int  CycleLimit = 400000;

  typedef struct packed {
    logic signed [15:0] m00, m02, m10, m11, m12, m20, m22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    pole_e              pole;
  } euler_t;

  typedef struct packed {
    matrix_t m;
    logic    known;
    euler_t  res;
  } vector_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [14:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  rotation_matrix_to_euler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Clock with a period of 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int unsigned thr_model = ThrReset;
  euler_t      angle_q[$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          got_cnt = 0;
  int          pole_cnt = 0;
  int          hold_left = 0;
  bit          calm = 1'b0;
  longint      cyc = 0;

  // Vectoring CORDIC arctangent on Q1.22 operands, result in Q3.13.
  function automatic longint cordic_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(AngPi) : -longint'(AngPi);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicStages && i < TabLen; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += longint'(AtanTab[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z -= longint'(AtanTab[i]);
      end
    end
    return (z + 64) >>> 7;
  endfunction

  // Floor of the square root, one result bit (two radicand bits) per step.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Euler angles of one matrix under the current pole threshold.
  function automatic euler_t euler_of(matrix_t m);
    euler_t r;
    longint s, s22, thr;
    thr = longint'(thr_model);
    s = longint'(m.m10);
    if (s > thr || s < -thr) begin
      r.pole  = (s > thr) ? POLE_NORTH : POLE_SOUTH;
      r.roll  = '0;
      r.pitch = (s > thr) ? PitchHalfPi : -PitchHalfPi;
      r.yaw   = 16'(cordic_angle(longint'(m.m02) * 256, longint'(m.m22) * 256));
    end else begin
      r.pole = POLE_NONE;
      r.roll = 16'(cordic_angle(-longint'(m.m12) * 256, longint'(m.m11) * 256));
      if (s > 16384) s = 16384;
      if (s < -16384) s = -16384;
      s22 = s * 256;
      r.pitch = 15'(cordic_angle(s22,
                    longint'(int_sqrt((64'd1 << 44) - 64'(s22 * s22)))));
      r.yaw  = 16'(cordic_angle(-longint'(m.m20) * 256, longint'(m.m00) * 256));
    end
    return r;
  endfunction

  function automatic vector_t row(int a, int b, int c, int d, int e, int f, int g,
                                  bit known = 0, int pole = 0);
    vector_t v;
    v.m = {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g)};
    v.known = known;
    v.res.roll  = '0;
    v.res.yaw   = '0;
    v.res.pole  = pole_e'(pole);
    v.res.pitch = (pole == POLE_NORTH) ? PitchHalfPi :
                  (pole == POLE_SOUTH) ? -PitchHalfPi : '0;
    return v;
  endfunction

  // One field: mostly in range, sometimes any 16-bit pattern.
  function automatic int rand_entry();
    if ($urandom_range(9) == 0) return int'($urandom_range(65535));
    return $urandom_range(32768) - 16384;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    int t;
    m = {16'(rand_entry()), 16'(rand_entry()), 16'(rand_entry()), 16'(rand_entry()),
         16'(rand_entry()), 16'(rand_entry()), 16'(rand_entry())};
    t = int'(thr_model);
    // Place the sine of pitch on or next to the pole boundary, or at zero, now and then.
    case ($urandom_range(7))
      0: m.m10 = 16'(t + $urandom_range(2) - 1);
      1: m.m10 = 16'(-t + $urandom_range(2) - 1);
      2: m.m10 = '0;
      default: ;
    endcase
    return m;
  endfunction

  // Offer one matrix and wait for its transfer; idle bursts follow at random.
  task automatic send(vector_t v);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v.m.m22, v.m.m20, v.m.m12, v.m.m11, v.m.m10, v.m.m02, v.m.m00};
    do @(posedge clk_i); while (!s_axis_tready);
    angle_q.push_back(v.known ? v.res : euler_of(v.m));
    sent_cnt++;
    if (!calm && $urandom_range(5) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(16)) @(negedge clk_i);
    end
  endtask

  // Write the threshold once the pipeline has drained.
  task automatic set_threshold(int unsigned thr);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 15'(thr);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_model = thr & 15'h7fff;
  endtask

  // Receiver readiness: random stall bursts, or one long hold when requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(5) == 0) begin
      hold_left = $urandom_range(16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest prediction.
  always @(posedge clk_i) begin
    euler_t want, got;
    cyc++;
    if (cyc > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, angle_q.size());
      $display("rotation_matrix_to_euler regression: fail");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[30:16], m_axis_tdata[46:31],
             pole_e'(m_axis_tuser)};
      got_cnt++;
      if (got.pole != POLE_NONE) pole_cnt++;
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, got);
        err_cnt++;
      end else begin
        want = angle_q.pop_front();
        if (got.roll !== want.roll || got.pitch !== want.pitch ||
            got.yaw !== want.yaw || got.pole !== want.pole) begin
          $display("%0t: expected roll %0d pitch %0d yaw %0d pole %0d",
                   $time, want.roll, want.pitch, want.yaw, want.pole);
          $display("%0t: actual   roll %0d pitch %0d yaw %0d pole %0d",
                   $time, got.roll, got.pitch, got.yaw, got.pole);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    vector_t     dir[$];
    int unsigned thr_set[5];
    thr_set = '{0, 32767, 16384, 1, 0};
    thr_set[4] = $urandom_range(16384);

    // Extremes, the pole boundaries and the special angles.
    dir.push_back(row(0, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(16384, 0, 0, 16384, 0, 0, 16384));
    dir.push_back(row(16384, 16384, 16384, 16384, 16384, 16384, 16384));
    dir.push_back(row(0, 0, 16384, 0, 0, 0, 0, 1, POLE_NORTH));
    dir.push_back(row(0, 0, -16384, 0, 0, 0, 0, 1, POLE_SOUTH));
    dir.push_back(row(-16384, -16384, -16384, -16384, -16384, -16384, -16384));
    dir.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    dir.push_back(row(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    dir.push_back(row(5, 7, ThrReset, 9, 11, 13, 15));
    dir.push_back(row(5, 7, ThrReset + 1, 9, 11, 13, 15));
    dir.push_back(row(5, 7, -ThrReset, 9, 11, 13, 15));
    dir.push_back(row(5, 7, -ThrReset - 1, 9, 11, 13, 15));
    dir.push_back(row(-16384, 0, 0, -16384, 0, 0, 16384));
    dir.push_back(row(-16384, 0, 0, -16384, 0, 16384, 16384));
    dir.push_back(row(0, 0, 16383, 0, 0, 0, 0, 1, POLE_NORTH));
    dir.push_back(row(0, -16384, 16384, 0, 0, 0, -16384, 0));
    dir.push_back(row(0, 16384, -16384, 0, 0, 0, -16384));
    dir.push_back(row(11585, 0, 11585, 11585, -11585, -11585, 11585));
    dir.push_back(row(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    dir.push_back(row(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir[i]) send(dir[i]);

    // Random matrices over several thresholds; one long output hold early on.
    foreach (thr_set[p]) begin
      set_threshold(thr_set[p]);
      if (p == 0) hold_left = 300;
      if (p == 4) calm = 1'b1;
      repeat (106) send('{m: rand_matrix(), known: 1'b0, res: '0});
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
    $display("Sent %0d matrices over six pole thresholds; %0d results checked, %0d poles.",
             sent_cnt, got_cnt, pole_cnt);
    if (err_cnt == 0 && angle_q.size() == 0) begin
      $display("rotation_matrix_to_euler regression: pass");
    end else begin
      $display("rotation_matrix_to_euler regression: fail");
    end
    $finish;
  end

endmodule

[rotation_matrix_to_euler.f]
rtl/core/rme_pkg.sv
rtl/core/rme_cordic.sv
rtl/core/rotation_matrix_to_euler.sv
tb/rotation_matrix_to_euler_test.sv
